// ===== sv/pair_score_remap_max_top_assert.svh =====
// ----------------------------------------------------------------------------
// pair_score_remap_max assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PAIR_SCORE_REMAP_MAX_TOP_ASSERT_SVH
`define PAIR_SCORE_REMAP_MAX_TOP_ASSERT_SVH

// same-cycle implication
`define PSRM_ASSERT_NOW(label, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psrm check failed");

// next-cycle implication
`define PSRM_ASSERT_NEXT(label, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psrm check failed");

`endif

// ===== sv/psrm_pkg.sv =====
// ----------------------------------------------------------------------------
// psrm_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package psrm_pkg;

  localparam int MAX_PROBES  = 1024;
  localparam int MAX_SYMBOLS = 256;
  localparam int MAX_ENTRIES = 2048;
  localparam int PAIR_SLOTS  = MAX_SYMBOLS * (MAX_SYMBOLS - 1) / 2;
  localparam logic [31:0] SCORE_INIT = 32'hC2C8_0000;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_SCORE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ID   = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  typedef struct packed {
    logic cap;
    logic stat_cap;
    logic ld_wr;
    logic clr;
    logic fe_rd_a;
    logic fe_rd_b;
    logic fe_cap_a;
    logic fe_cap_b;
    logic ent_rd_i;
    logic ent_rd_j;
    logic cap_i;
    logic cap_j;
    logic inc_i;
    logic inc_j;
    logic mul;
    logic pb_rd_k;
    logic pb_upd;
    logic pb_rd_idx;
    logic rd_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] req;
    logic       ld_ok;
    logic       pair_ok;
    logic       idx_ok;
    logic       fe_ok;
    logic       i_live;
    logic       j_live;
    logic       match_a;
    logic       match_b;
    logic       fold_ok;
    logic       out_free;
  } stat_t;

  // IEEE single a > b, ordered
  function automatic logic float_gt(logic [31:0] a, logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic gt;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (a_nan || b_nan || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))) begin
      gt = 1'b0;
    end else if (a[31] != b[31]) begin
      gt = !a[31];
    end else if (!a[31]) begin
      gt = a[30:0] > b[30:0];
    end else begin
      gt = a[30:0] < b[30:0];
    end
    return gt;
  endfunction

endpackage

// ===== sv/psrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// psrm_ctrl
// Sequencer: clearing pass, request dispatch and the map-entry walk.
// ----------------------------------------------------------------------------
module psrm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  psrm_pkg::stat_t stat,
  output psrm_pkg::cmd_t  cmd
);
  import psrm_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_FEA, S_FEB, S_FEW, S_RI, S_RIW,
    S_RJ, S_RJW, S_MUL, S_PBR, S_PBW, S_RDP, S_RDW, S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.stat_cap = 1'b1;
        state_next = S_FIN;
        case (stat.req)
          REQ_LOAD: cmd.ld_wr = stat.ld_ok;
          REQ_SCORE: if (stat.pair_ok) state_next = S_FEA;
          REQ_READ: if (stat.idx_ok) state_next = S_RDP;
          default: state_next = S_FIN;
        endcase
      end
      S_FEA: begin
        cmd.fe_rd_a = 1'b1;
        state_next = S_FEB;
      end
      S_FEB: begin
        cmd.fe_rd_b = 1'b1;
        cmd.fe_cap_a = 1'b1;
        state_next = S_FEW;
      end
      S_FEW: begin
        cmd.fe_cap_b = 1'b1;
        state_next = stat.fe_ok ? S_RI : S_FIN;
      end
      S_RI: begin
        if (stat.i_live) begin
          cmd.ent_rd_i = 1'b1;
          state_next = S_RIW;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RIW: begin
        if (stat.match_a) begin
          cmd.cap_i = 1'b1;
          state_next = S_RJ;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RJ: begin
        if (stat.j_live) begin
          cmd.ent_rd_j = 1'b1;
          state_next = S_RJW;
        end else begin
          cmd.inc_i = 1'b1;
          state_next = S_RI;
        end
      end
      S_RJW: begin
        if (stat.match_b) begin
          cmd.cap_j = 1'b1;
          state_next = S_MUL;
        end else begin
          cmd.inc_i = 1'b1;
          state_next = S_RI;
        end
      end
      S_MUL: begin
        if (stat.fold_ok) begin
          cmd.mul = 1'b1;
          state_next = S_PBR;
        end else begin
          cmd.inc_j = 1'b1;
          state_next = S_RJ;
        end
      end
      S_PBR: begin
        cmd.pb_rd_k = 1'b1;
        state_next = S_PBW;
      end
      S_PBW: begin
        cmd.pb_upd = 1'b1;
        cmd.inc_j = 1'b1;
        state_next = S_RJ;
      end
      S_RDP: begin
        cmd.pb_rd_idx = 1'b1;
        state_next = S_RDW;
      end
      S_RDW: begin
        cmd.rd_cap = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/psrm_dp.sv =====
// ----------------------------------------------------------------------------
// psrm_dp
// Datapath: map store, first-entry table, pair store and result register.
// ----------------------------------------------------------------------------
module psrm_dp (
  input  logic            clk,
  input  logic            rst,
  input  psrm_pkg::cmd_t  cmd,
  output psrm_pkg::stat_t stat,
  input  logic [1:0]      req_type,
  input  logic [9:0]      probe_a,
  input  logic [9:0]      probe_b,
  input  logic [7:0]      symbol_id,
  input  logic [31:0]     score_bits,
  input  logic [14:0]     pair_index,
  input  logic [8:0]      symbol_count,
  input  logic [10:0]     probe_count,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [31:0]     score_out
);
  import psrm_pkg::*;

  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int PW = $clog2(MAX_PROBES);
  localparam int KW = $clog2(PAIR_SLOTS);

  logic [17:0]    ent_mem [MAX_ENTRIES];
  logic [EW:0]    fe_mem  [MAX_PROBES];
  logic [31:0]    pb_mem  [PAIR_SLOTS];

  logic [1:0]  req;
  logic [9:0]  pa;
  logic [9:0]  pb;
  logic [7:0]  sym;
  logic [31:0] score;
  logic [14:0] pidx;

  logic [8:0]  n_eff;
  logic [10:0] np_eff;
  logic [15:0] slots;
  logic [EW:0] count;
  logic [9:0]  last_probe;
  logic [KW-1:0] clr_addr;

  logic [EW:0]    fe_q;
  logic [17:0]    ent_q;
  logic [31:0]    pb_q;
  logic           va;
  logic [EW:0]    i_idx;
  logic [EW:0]    j_idx;
  logic [EW:0]    j0;
  logic [7:0]     sym_i;
  logic [8:0]     lo;
  logic [8:0]     hi;
  logic [17:0]    rest;
  logic [KW-1:0]  k_reg;
  logic [15:0]    k_full;
  logic [8:0]     n_lo;
  logic [17:0]    slots_full;
  logic [1:0]     res_status;
  logic [31:0]    res_score;
  logic [1:0]     st_calc;
  logic [1:0]     ld_status;
  logic [7:0]     ent_sym;
  logic [9:0]     ent_probe;

  assign n_eff  = (symbol_count < 9'(MAX_SYMBOLS)) ? symbol_count : 9'(MAX_SYMBOLS);
  assign np_eff = (probe_count < 11'(MAX_PROBES)) ? probe_count : 11'(MAX_PROBES);
  assign slots_full = n_eff * (n_eff - 9'd1);
  assign ent_sym   = ent_q[7:0];
  assign ent_probe = ent_q[17:8];
  assign n_lo   = n_eff - lo;
  assign k_full = slots - rest[16:1] + {7'd0, hi} - {7'd0, lo} - 16'd1;

  always_comb begin
    if (count == (EW+1)'(MAX_ENTRIES)) begin
      ld_status = ST_FULL;
    end else if ({1'b0, pa} >= np_eff || {1'b0, sym} >= n_eff) begin
      ld_status = ST_ID;
    end else if (count != '0 && pa < last_probe) begin
      ld_status = ST_ID;
    end else begin
      ld_status = ST_OK;
    end
  end

  assign stat.clr_done = (clr_addr == KW'(PAIR_SLOTS - 1));
  assign stat.req      = req;
  assign stat.ld_ok    = (ld_status == ST_OK);
  assign stat.pair_ok  = (pa < pb) && ({1'b0, pb} < np_eff);
  assign stat.idx_ok   = ({1'b0, pidx} < slots) && ({1'b0, pidx} < 16'(PAIR_SLOTS));
  assign stat.fe_ok    = va && fe_q[EW];
  assign stat.i_live   = i_idx < count;
  assign stat.j_live   = j_idx < count;
  assign stat.match_a  = ent_probe == pa;
  assign stat.match_b  = ent_probe == pb;
  assign stat.fold_ok  = (lo != hi) && (hi < n_eff);
  assign stat.out_free = !out_valid || out_ready;

  always_comb begin
    case (req)
      REQ_LOAD:  st_calc = ld_status;
      REQ_SCORE: st_calc = stat.pair_ok ? ST_OK : ST_BAD;
      REQ_READ:  st_calc = stat.idx_ok ? ST_OK : ST_BAD;
      default:   st_calc = ST_BAD;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.ld_wr) begin
      ent_mem[count[EW-1:0]] <= {pa, sym};
    end
    ent_q <= ent_mem[cmd.ent_rd_i ? i_idx[EW-1:0] : j_idx[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr && clr_addr < KW'(MAX_PROBES)) begin
      fe_mem[clr_addr[PW-1:0]] <= '0;
    end else if (cmd.ld_wr && (count == '0 || pa != last_probe)) begin
      fe_mem[pa] <= {1'b1, count[EW-1:0]};
    end
    fe_q <= fe_mem[cmd.fe_rd_b ? pb : pa];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      pb_mem[clr_addr] <= SCORE_INIT;
    end else if (cmd.pb_upd && float_gt(score, pb_q)) begin
      pb_mem[k_reg] <= score;
    end
    pb_q <= pb_mem[cmd.pb_rd_idx ? pidx : k_full[KW-1:0]];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    slots <= (n_eff >= 9'd2) ? slots_full[16:1] : 16'd0;
    if (cmd.cap) begin
      req   <= req_type;
      pa    <= probe_a;
      pb    <= probe_b;
      sym   <= symbol_id;
      score <= score_bits;
      pidx  <= pair_index;
    end
    if (cmd.stat_cap) begin
      res_status <= st_calc;
      res_score  <= '0;
    end
    if (cmd.rd_cap) res_score <= pb_q;
    if (cmd.fe_cap_a) begin
      va    <= fe_q[EW];
      i_idx <= {1'b0, fe_q[EW-1:0]};
    end
    if (cmd.fe_cap_b) j0 <= {1'b0, fe_q[EW-1:0]};
    if (cmd.cap_i) begin
      sym_i <= ent_sym;
      j_idx <= j0;
    end
    if (cmd.inc_i) i_idx <= i_idx + 1'b1;
    if (cmd.inc_j) j_idx <= j_idx + 1'b1;
    if (cmd.cap_j) begin
      lo <= {1'b0, (sym_i < ent_sym) ? sym_i : ent_sym};
      hi <= {1'b0, (sym_i < ent_sym) ? ent_sym : sym_i};
    end
    if (cmd.mul) rest <= n_lo * (n_lo - 9'd1);
    if (cmd.pb_rd_k) k_reg <= k_full[KW-1:0];
    if (cmd.out_load) begin
      status    <= res_status;
      score_out <= res_score;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      last_probe <= '0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + 1'b1;
      if (cmd.ld_wr) begin
        count      <= count + 1'b1;
        last_probe <= pa;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/pair_score_remap_max_top.sv =====
// ----------------------------------------------------------------------------
// pair_score_remap_max_top
// Probe-to-symbol map and symbol-pair maximum score store.
// ----------------------------------------------------------------------------
// Input stream s_*: one request word per transfer, kind in s_tuser (0 load map
// entry, 1 probe pair score, 2 read pair score). Output stream m_*: one result
// word per request, status and score. Registers symbol_count (0x0) and
// probe_count (0x4) sit on the APB port and are to be written by the user only
// while idle, which the block itself does not enforce. After reset the block
// runs a clearing pass over the pair store (and the first-entry table) with
// s_tready low; APB writes still work. Requests are handled one at a time:
// load and bad requests go from dispatch to the result, a read first reads the
// pair store, and a score request walks each entry of probe a against those of
// probe b, with a read-then-write of the pair store per stored pair; its pace
// is set by the single read port of the map store and that read-then-write.
// The next word is accepted in the cycle after the result is loaded, even while
// it still waits in the output register; a stalled receiver holds m_tvalid and
// the word, and the block stops only when a second result is ready.
// ----------------------------------------------------------------------------
module pair_score_remap_max_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // probe_a, probe_b, symbol_id, score_bits, pair_index
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status, score_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psrm_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [8:0]  symbol_count;
  logic [10:0] probe_count;
  logic [1:0]  status;
  logic [31:0] score_out;

  assign pready  = 1'b1;
  assign prdata  = paddr[2] ? {21'd0, probe_count} : {23'd0, symbol_count};
  assign m_tdata = {6'd0, score_out, status};

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= 9'(MAX_SYMBOLS);
      probe_count  <= 11'(MAX_PROBES);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        probe_count <= pwdata[10:0];
      end else begin
        symbol_count <= pwdata[8:0];
      end
    end
  end

  psrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psrm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (s_tuser),
    .probe_a      (s_tdata[9:0]),
    .probe_b      (s_tdata[19:10]),
    .symbol_id    (s_tdata[27:20]),
    .score_bits   (s_tdata[59:28]),
    .pair_index   (s_tdata[74:60]),
    .symbol_count (symbol_count),
    .probe_count  (probe_count),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .score_out    (score_out)
  );

endmodule

// ===== sv/psrm_check.sv =====
// ----------------------------------------------------------------------------
// psrm_check
// Port-level checks on the result stream and the register port.
// ----------------------------------------------------------------------------
`include "pair_score_remap_max_top_assert.svh"

module psrm_check (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        pready
);

  `PSRM_ASSERT_NEXT(a_hold_valid, rst, m_tvalid && !m_tready, m_tvalid)
  `PSRM_ASSERT_NEXT(a_hold_word, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `PSRM_ASSERT_NOW(a_fail_no_score, rst, m_tvalid && m_tdata[1:0] != 2'd0,
    m_tdata[33:2] == 32'd0)
  `PSRM_ASSERT_NOW(a_pad_zero, rst, m_tvalid, m_tdata[39:34] == 6'd0)
  `PSRM_ASSERT_NOW(a_pready, rst, 1'b1, pready)

endmodule

bind pair_score_remap_max_top psrm_check u_psrm_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);
